[sv/double_to_fixed_quantizer_assert.svh]
// Assertion macros for the double to fixed quantizer.
`ifndef DOUBLE_TO_FIXED_QUANTIZER_ASSERT_SVH
`define DOUBLE_TO_FIXED_QUANTIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define DFQ_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define DFQ_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define DFQ_ASSERT_IMPL(label, clk, rst_n, a, c)
`define DFQ_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[sv/dfq_pkg.sv]
// ----------------------------------------------------------------------------
// dfq_pkg: shared constants of the double to fixed quantizer
// Format codes and field widths.
// ----------------------------------------------------------------------------
package dfq_pkg;
  localparam int unsigned WordW = 34;
  localparam int unsigned DblW  = 64;
  typedef enum logic [1:0] {
    FMT_Q8_8   = 2'd0,
    FMT_Q16_16 = 2'd1,
    FMT_Q18_16 = 2'd2,
    FMT_BAD    = 2'd3
  } fmt_t;
endpackage

[sv/double_to_fixed_quantizer.sv]
// The start transfer passes through vld_r[0] to vld_r[3], which is out_valid,
// alongside the stage registers. Throughput: one item per cycle.
// Stages: decode/shift-in, align shift, wrap and leading-zero count, repack.
// Reset: synchronous active-low rst_n clears the valid bits and the format
// register (Q8.8); the receiver cannot stall, so results never wait.
// ----------------------------------------------------------------------------
// double_to_fixed_quantizer
// Converts a binary64 value to a wrapped fixed word and its readback double.
// ----------------------------------------------------------------------------
`include "double_to_fixed_quantizer_assert.svh"
module double_to_fixed_quantizer import dfq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [DblW-1:0]   in_value_bits,
  output logic              out_valid,
  output logic [WordW-1:0]  out_fixed_word,
  output logic [DblW-1:0]   out_quantized_bits,
  output logic              out_out_of_range,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_format_select
);

  logic [1:0] fmt_r;
  logic [3:0] vld_r;

  // Stage 1 registers.
  logic        s1_bad_r, s1_neg_r;
  logic [52:0] s1_mant_r;
  logic [11:0] s1_exp_r;
  logic [1:0]  s1_fmt_r;
  // Stage 2 registers.
  logic        s2_bad_r;
  logic [1:0]  s2_fmt_r;
  logic [47:0] s2_word_r;
  // Stage 3 registers.
  logic        s3_bad_r;
  logic [1:0]  s3_fmt_r;
  logic [WordW-1:0] s3_word_r;
  logic [5:0]  s3_lz_r;
  // Output registers.
  logic [WordW-1:0] o_word_r;
  logic [DblW-1:0]  o_q_r;
  logic             o_bad_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Stage 1 decode: range test on the unscaled value.
  logic        d_sign;
  logic [10:0] d_e;
  logic [51:0] d_m;
  logic        d_bad;
  always_comb begin
    d_sign = in_value_bits[63];
    d_e    = in_value_bits[62:52];
    d_m    = in_value_bits[51:0];
    // |v| < 2^31 ok; v == -2^31 exactly ok.
    if (d_e == 11'h7ff)        d_bad = 1'b1;
    else if (d_e < 11'd1054)   d_bad = 1'b0;
    else if (d_e == 11'd1054 && d_sign && d_m == '0) d_bad = 1'b0;
    else                       d_bad = 1'b1;
    if (fmt_t'(fmt_r) == FMT_BAD) d_bad = 1'b1;
  end

  // Stage 2: fixed = floor(m * 2^(e-1075+F)) as a 48-bit two's complement.
  logic [11:0]  a_sh;
  logic [104:0] a_full;
  logic [47:0]  a_mag;
  logic         a_frac;
  logic [47:0]  a_word;
  always_comb begin
    // Right shift amount: 1075 - e - F, clamped.
    a_sh = 12'd1075 - s1_exp_r -
           ((fmt_t'(s1_fmt_r) == FMT_Q8_8) ? 12'd8 : 12'd16);
    if (a_sh[11]) a_sh = 12'd0;   // cannot happen in range, kept safe
    if (a_sh > 12'd104) a_sh = 12'd104;
    a_full = {s1_mant_r, 52'd0} >> a_sh[6:0];
    a_mag  = a_full[99:52];
    // Beyond 52 places the whole mantissa is fraction.
    if (a_sh > 12'd52) a_frac = |s1_mant_r;
    else               a_frac = |a_full[51:0];
    if (s1_neg_r) a_word = ~a_mag + 48'd1 - {47'd0, a_frac};
    else          a_word = a_mag;
  end

  // Stage 3: wrap to format width and count leading zeros.
  logic [WordW-1:0] w_word;
  logic [5:0]       w_lz;
  always_comb begin
    unique case (fmt_t'(s2_fmt_r))
      FMT_Q8_8:   w_word = {18'd0, s2_word_r[15:0]};
      FMT_Q16_16: w_word = {2'd0, s2_word_r[31:0]};
      default:    w_word = s2_word_r[WordW-1:0];
    endcase
    w_lz = 6'd34;
    for (int i = 0; i < WordW; i++) begin
      if (w_word[i]) w_lz = 6'(WordW - 1 - i);
    end
  end

  // Stage 4: pack the readback double.
  logic [WordW-1:0] p_norm;
  logic [10:0]      p_exp;
  logic [DblW-1:0]  p_q;
  always_comb begin
    p_norm = s3_word_r << s3_lz_r;
    p_exp  = 11'd1023 + 11'd33 - {5'd0, s3_lz_r} -
             ((fmt_t'(s3_fmt_r) == FMT_Q8_8) ? 11'd8 : 11'd16);
    if (s3_word_r == '0) p_q = '0;
    else p_q = {1'b0, p_exp, p_norm[32:0], 19'd0};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 2'd0;
      vld_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) fmt_r <= cfg_format_select;
      vld_r <= {vld_r[2:0], start && !busy};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    s1_bad_r  <= d_bad;
    s1_neg_r  <= d_sign;
    s1_mant_r <= {d_e != 11'd0, d_m};
    s1_exp_r  <= {1'b0, (d_e == 11'd0) ? 11'd1 : d_e};
    s1_fmt_r  <= fmt_r;
    s2_bad_r  <= s1_bad_r;
    s2_fmt_r  <= s1_fmt_r;
    s2_word_r <= a_word;
    s3_bad_r  <= s2_bad_r;
    s3_fmt_r  <= s2_fmt_r;
    s3_word_r <= w_word;
    s3_lz_r   <= w_lz;
    o_bad_r   <= s3_bad_r;
    o_word_r  <= s3_bad_r ? '0 : s3_word_r;
    o_q_r     <= s3_bad_r ? '0 : p_q;
  end

  assign out_valid          = vld_r[3];
  assign out_fixed_word     = o_word_r;
  assign out_quantized_bits = o_q_r;
  assign out_out_of_range   = o_bad_r;

  // Checks.
  `DFQ_ASSERT_NEXT(a_lat, clk, rst_n, vld_r[2], out_valid)
  `DFQ_ASSERT_IMPL(a_bad_zero, clk, rst_n, out_valid && out_out_of_range,
    out_fixed_word == '0 && out_quantized_bits == '0)
  `DFQ_ASSERT_IMPL(a_q_sign, clk, rst_n, out_valid, !out_quantized_bits[63])

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of double_to_fixed_quantizer
// Drives binary64 patterns through every format setting. A directed stimulus
// table runs first, then random items. Each result is checked against a table
// entry or an in-bench model of the floor, wrap and readback conversion.
// ----------------------------------------------------------------------------
module tb;
  import dfq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    logic [WordW-1:0] word;
    logic [DblW-1:0]  qbits;
    logic             oor;
  } quant_t;

  typedef struct {
    logic [DblW-1:0] bits;
    bit              typed;
    quant_t          res;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [DblW-1:0]   in_value_bits;
  logic              out_valid;
  logic [WordW-1:0]  out_fixed_word;
  logic [DblW-1:0]   out_quantized_bits;
  logic              out_out_of_range;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_format_select;

  fmt_t   fmt_shadow;
  quant_t pending_q[$];
  int     mismatches;
  int     cycles;

  double_to_fixed_quantizer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_value_bits      (in_value_bits),
    .out_valid          (out_valid),
    .out_fixed_word     (out_fixed_word),
    .out_quantized_bits (out_quantized_bits),
    .out_out_of_range   (out_out_of_range),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_format_select  (cfg_format_select)
  );

  // Clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Floor of value * 2^F, wrapped to the format width, and its readback.
  function automatic quant_t quantize(logic [DblW-1:0] bits, fmt_t fmt);
    quant_t      r;
    real         v;
    real         scale;
    real         s;
    longint      t;
    int unsigned fb;
    int unsigned wd;
    logic [63:0] w64;
    begin
      r.word  = '0;
      r.qbits = '0;
      r.oor   = 1'b1;
      v = $bitstoreal(bits);
      // Unknown format, NaN, infinity and integer parts beyond int32 reject.
      if (fmt == FMT_BAD || !(v >= -2147483648.0 && v < 2147483648.0)) begin
        return r;
      end
      fb = (fmt == FMT_Q8_8) ? 8 : 16;
      wd = (fmt == FMT_Q8_8) ? 16 : (fmt == FMT_Q16_16) ? 32 : 34;
      scale = 2.0 ** fb;
      s = v * scale;
      // The cast rounds to nearest, so one step down at most gives the floor.
      t = longint'(s);
      if (real'(t) > s) begin
        t = t - 1;
      end
      w64 = t;
      w64 = w64 & ((64'd1 << wd) - 64'd1);
      r.word  = w64[WordW-1:0];
      r.qbits = $realtobits(real'(longint'(w64)) / scale);
      r.oor   = 1'b0;
      return r;
    end
  endfunction

  // Result checker: every strobed result is matched to the oldest expectation.
  always @(posedge clk) begin
    quant_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
          $display("unexpected result word=%h q=%h oor=%b",
                   out_fixed_word, out_quantized_bits, out_out_of_range);
        end
      end else begin
        e = pending_q.pop_front();
        if (out_fixed_word !== e.word || out_quantized_bits !== e.qbits ||
            out_out_of_range !== e.oor) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("mismatch exp word=%h q=%h oor=%b, got word=%h q=%h oor=%b",
                     e.word, e.qbits, e.oor,
                     out_fixed_word, out_quantized_bits, out_out_of_range);
          end
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Idle gap: mostly none or short, now and then long.
  function automatic int gap_len();
    int p;
    begin
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
    end
  endfunction

  // One input transfer; the expectation is queued at the accepting edge.
  task automatic send_value(logic [DblW-1:0] bits, bit typed, quant_t res);
    bit ok;
    int g;
    begin
      start         <= 1'b1;
      in_value_bits <= bits;
      forever begin
        @(negedge clk);
        ok = !busy;
        @(posedge clk);
        if (ok) break;
      end
      pending_q.push_back(typed ? res : quantize(bits, fmt_shadow));
      g = gap_len();
      if (g > 0) begin
        start <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  // Format register write; only issued with nothing in flight.
  task automatic write_format(logic [1:0] fmt);
    bit ok;
    begin
      cfg_valid         <= 1'b1;
      cfg_format_select <= fmt;
      forever begin
        @(negedge clk);
        ok = cfg_ready;
        @(posedge clk);
        if (ok) break;
      end
      fmt_shadow = fmt_t'(fmt);
      cfg_valid <= 1'b0;
      repeat ($urandom_range(3)) @(posedge clk);
    end
  endtask

  // Wait until every result is back, then let the pipeline settle.
  task automatic drain();
    begin
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clk);
      repeat (8) @(posedge clk);
    end
  endtask

  // Random value: mostly within the int32 range, some near its edges,
  // some fully random patterns and specials.
  function automatic logic [DblW-1:0] random_value();
    logic [DblW-1:0] b;
    int              p;
    begin
      b = {$urandom, $urandom};
      p = $urandom_range(99);
      if (p < 65) begin
        b[62:52] = 11'($urandom_range(1023 + 31, 1023 - 24));
      end else if (p < 75) begin
        b[62:52] = 11'($urandom_range(1023 + 32, 1023 + 30));
      end else if (p < 80) begin
        b[62:52] = 11'h7FF;
        if ($urandom_range(1)) b[51:0] = '0;
      end else if (p < 85) begin
        b[62:52] = '0;
      end
      return b;
    end
  endfunction

  localparam quant_t Rejected = '{word: '0, qbits: '0, oor: 1'b1};
  localparam quant_t Zero     = '{word: '0, qbits: '0, oor: 1'b0};

  // Directed rows, run in Q8.8 straight after reset.
  stim_row_t dir_rows[] = '{
    '{64'h0000_0000_0000_0000, 1'b1, Zero},
    '{64'h8000_0000_0000_0000, 1'b1, Zero},
    '{64'h3FF0_0000_0000_0000, 1'b1, '{34'h100, 64'h3FF0_0000_0000_0000, 1'b0}},
    '{64'h7FF8_0000_0000_0000, 1'b1, Rejected},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, Rejected},
    '{64'h7FF0_0000_0000_0000, 1'b1, Rejected},
    '{64'hFFF0_0000_0000_0000, 1'b1, Rejected},
    '{64'h41E0_0000_0000_0000, 1'b1, Rejected},
    '{64'hC1E0_0000_0020_0000, 1'b1, Rejected},
    '{64'h7FEF_FFFF_FFFF_FFFF, 1'b1, Rejected},
    '{64'hC1E0_0000_0000_0000, 1'b0, Zero},
    '{64'h41DF_FFFF_FFFF_FFFF, 1'b0, Zero},
    '{64'hBFE0_0000_0000_0000, 1'b0, Zero},
    '{64'hBFF0_0000_0000_0000, 1'b0, Zero},
    '{64'h0000_0000_0000_0001, 1'b0, Zero},
    '{64'h800F_FFFF_FFFF_FFFF, 1'b0, Zero},
    '{64'h3F70_0000_0000_0000, 1'b0, Zero},
    '{64'h3F6F_FFFF_FFFF_FFFF, 1'b0, Zero},
    '{64'h40EF_FFFF_FFFF_FFFF, 1'b0, Zero},
    '{64'h400921FB54442D18, 1'b0, Zero}
  };

  // Stimulus sequence.
  initial begin
    logic [1:0] fmt_seq[] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1};
    quant_t     none;
    none = Zero;
    mismatches = 0;
    cycles = 0;
    fmt_shadow = FMT_Q8_8;
    rst_n = 1'b0;
    start = 1'b0;
    in_value_bits = '0;
    cfg_valid = 1'b0;
    cfg_format_select = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_value(dir_rows[i].bits, dir_rows[i].typed, dir_rows[i].res);
    end
    // The directed rows again under each remaining format.
    for (int f = 1; f < 4; f++) begin
      drain();
      write_format(2'(f));
      foreach (dir_rows[i]) send_value(dir_rows[i].bits, 1'b0, none);
    end

    foreach (fmt_seq[k]) begin
      drain();
      write_format(fmt_seq[k]);
      repeat (k == 2 ? 100 : 280) send_value(random_value(), 1'b0, none);
    end
    drain();

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/dfq_pkg.sv
sv/double_to_fixed_quantizer.sv
bench/tb.sv
